// ===== rtl/core/pmseq_pkg.sv =====
// Package: shared types, mode codes and register constants for the precharge mode sequencer.
`default_nettype none

package pmseq_pkg;

    localparam logic [2:0] MODE_OFF       = 3'd0;
    localparam logic [2:0] MODE_PRECHARGE = 3'd1;
    localparam logic [2:0] MODE_RUN       = 3'd2;
    localparam logic [2:0] MODE_CHARGE    = 3'd3;
    localparam logic [2:0] MODE_FAILED    = 3'd4;

    localparam logic [1:0] CFG_SWITCH_VOLTAGE    = 2'd0;
    localparam logic [1:0] CFG_LIMIT_VOLTAGE     = 2'd1;
    localparam logic [1:0] CFG_PRECHARGE_WINDOW  = 2'd2;
    localparam logic [1:0] CFG_RELAY_DELAY_TICKS = 2'd3;

    localparam logic [9:0]  SWITCH_VOLTAGE_RESET    = 10'd300;
    localparam logic [9:0]  LIMIT_VOLTAGE_RESET     = 10'd1023;
    localparam logic [15:0] PRECHARGE_WINDOW_RESET  = 16'd5;
    localparam logic [7:0]  RELAY_DELAY_TICKS_RESET = 8'd25;
    localparam logic [7:0]  RELAY_DELAY_RESET       = 8'd25;

    typedef struct packed {
        logic [9:0]  switch_voltage;
        logic [9:0]  limit_voltage;
        logic [15:0] precharge_window;
        logic [7:0]  relay_delay_ticks;
    } cfg_t;

    typedef struct packed {
        logic        start_request;
        logic        vehicle_ready;
        logic        throttle_pressed;
        logic        charge_request;
        logic [9:0]  link_voltage;
        logic [31:0] time_now;
    } item_t;

    typedef struct packed {
        logic inverter_power;
        logic negative_contactor;
        logic coolant_pump;
        logic precharge_relay;
        logic main_contactor;
    } pins_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  relay_delay;
        logic        start_latched;
        logic        began_by_start;
        logic        began_by_charge;
        logic [31:0] precharge_start_time;
        pins_t       pins;
    } state_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] status_bits;
        pins_t      pins;
        logic       precharge_fault;
        logic       clear_errors;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/precharge_mode_sequencer_top.sv =====
// Top level of the precharge mode sequencer: input register, sequencer state, result register.
//
// Usage:
//   Each transfer on the input channel (in_valid/in_ready) is one control tick: start,
//   ready, throttle and charge flags, DC link voltage and the real-time counter value.
//   Each tick yields exactly one result transfer on the output channel (out_valid/
//   out_ready): mode after the tick, three status bits, the five held output pins and
//   the precharge_fault and clear_errors pulses.
//   A tick taken passes the input register, then the result register, before its
//   result shows. One tick per cycle while the receiver does not stall; the
//   sequencer state is updated in the cycle that moves a tick from the input
//   register to the result register.
//   When the receiver stalls, the result register holds, the input register fills, and
//   in_ready drops only while both are occupied.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high. Write only while no tick is in flight.
//   Reset (rst_n low, asynchronous): both channels empty, mode off, relay delay 25,
//   latches and pins cleared, registers back to 300 V, 1023 V, 5 and 25 ticks.
`default_nettype none

module precharge_mode_sequencer_top
    import pmseq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        start_request,
    input  wire logic        vehicle_ready,
    input  wire logic        throttle_pressed,
    input  wire logic        charge_request,
    input  wire logic [9:0]  link_voltage,
    input  wire logic [31:0] time_now,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       mode,
    output logic [2:0]       status_bits,
    output logic             inverter_power,
    output logic             negative_contactor,
    output logic             coolant_pump,
    output logic             precharge_relay,
    output logic             main_contactor,
    output logic             precharge_fault,
    output logic             clear_errors
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   item_reg;
    logic    item_valid_reg;
    logic    item_valid_next;
    state_t  state_reg;
    state_t  state_next;
    result_t step_result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    in_xfer;

    assign cfg_ready = 1'b1;

    pmseq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign in_item.start_request    = start_request;
    assign in_item.vehicle_ready    = vehicle_ready;
    assign in_item.throttle_pressed = throttle_pressed;
    assign in_item.charge_request   = charge_request;
    assign in_item.link_voltage     = link_voltage;
    assign in_item.time_now         = time_now;

    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_xfer)
            item_valid_next = 1'b1;
        else if (advance)
            item_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    pmseq_step u_step (
        .cfg        (cfg),
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg                 <= 1'b0;
            out_valid_reg                  <= 1'b0;
            state_reg.mode                 <= MODE_OFF;
            state_reg.relay_delay          <= RELAY_DELAY_RESET;
            state_reg.start_latched        <= 1'b0;
            state_reg.began_by_start       <= 1'b0;
            state_reg.began_by_charge      <= 1'b0;
            state_reg.precharge_start_time <= 32'd0;
            state_reg.pins                 <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            item_reg <= in_item;
        if (advance)
            result_reg <= step_result;
    end

    assign out_valid          = out_valid_reg;
    assign mode               = result_reg.mode;
    assign status_bits        = result_reg.status_bits;
    assign inverter_power     = result_reg.pins.inverter_power;
    assign negative_contactor = result_reg.pins.negative_contactor;
    assign coolant_pump       = result_reg.pins.coolant_pump;
    assign precharge_relay    = result_reg.pins.precharge_relay;
    assign main_contactor     = result_reg.pins.main_contactor;
    assign precharge_fault    = result_reg.precharge_fault;
    assign clear_errors       = result_reg.clear_errors;

`ifndef SYNTHESIS
    a_fault_enters_failed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && precharge_fault |-> mode == MODE_FAILED && !precharge_relay)
        else $error("precharge fault without failed mode or with relay closed");

    a_fault_excl_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(precharge_fault && clear_errors))
        else $error("precharge fault and clear errors in the same tick");

    a_flow_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (!item_valid_reg || !out_valid_reg || out_ready) |-> in_ready)
        else $error("input stalled while the pipeline can move");

    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("sequencer state changed without a tick");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/pmseq_cfg.sv =====
// Configuration register file: four sequencer thresholds written over the config channel.
`default_nettype none

module pmseq_cfg
    import pmseq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [15:0] wr_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_SWITCH_VOLTAGE:    cfg_next.switch_voltage    = wr_data[9:0];
                CFG_LIMIT_VOLTAGE:     cfg_next.limit_voltage     = wr_data[9:0];
                CFG_PRECHARGE_WINDOW:  cfg_next.precharge_window  = wr_data;
                CFG_RELAY_DELAY_TICKS: cfg_next.relay_delay_ticks = wr_data[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.switch_voltage    <= SWITCH_VOLTAGE_RESET;
            cfg_reg.limit_voltage     <= LIMIT_VOLTAGE_RESET;
            cfg_reg.precharge_window  <= PRECHARGE_WINDOW_RESET;
            cfg_reg.relay_delay_ticks <= RELAY_DELAY_TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pmseq_step.sv =====
// Next-state and result logic for one control tick of the mode sequencer.
`default_nettype none

module pmseq_step
    import pmseq_pkg::*;
(
    input  wire cfg_t   cfg,
    input  wire item_t  item,
    input  wire state_t state,
    output state_t      state_next,
    output result_t     result
);

    logic        below_switch;
    logic        at_limit;
    logic [2:0]  status;
    logic [7:0]  delay_dec;
    logic [31:0] deadline;
    logic        timed_out;
    logic        fault;
    logic        clr_err;
    state_t      nx;

    assign below_switch = item.link_voltage < cfg.switch_voltage;
    assign at_limit     = item.link_voltage >= cfg.limit_voltage;
    assign status       = {at_limit, below_switch, item.throttle_pressed};
    assign delay_dec    = (state.relay_delay != 8'd0) ? state.relay_delay - 8'd1 : 8'd0;
    assign deadline     = state.precharge_start_time + {16'd0, cfg.precharge_window};
    assign timed_out    = below_switch && (item.time_now > deadline);

    always_comb
    begin
        nx      = state;
        fault   = 1'b0;
        clr_err = 1'b0;
        case (state.mode)
            MODE_OFF:
            begin
                nx.began_by_start  = 1'b0;
                nx.began_by_charge = 1'b0;
                nx.pins            = '0;
                nx.start_latched   = 1'b0;
                if (!item.throttle_pressed && item.start_request && item.vehicle_ready)
                begin
                    nx.start_latched        = 1'b1;
                    nx.mode                 = MODE_PRECHARGE;
                    nx.precharge_start_time = item.time_now;
                    nx.began_by_start       = 1'b1;
                end
                if (item.charge_request)
                begin
                    nx.mode                 = MODE_PRECHARGE;
                    nx.precharge_start_time = item.time_now;
                    nx.began_by_charge      = 1'b1;
                end
                nx.relay_delay = cfg.relay_delay_ticks;
            end
            MODE_PRECHARGE:
            begin
                if (!item.charge_request)
                    nx.pins.inverter_power = 1'b1;
                nx.pins.negative_contactor = 1'b1;
                nx.pins.coolant_pump       = 1'b1;
                nx.relay_delay             = delay_dec;
                if (delay_dec == 8'd0)
                    nx.pins.precharge_relay = 1'b1;
                if (status == 3'd0)
                begin
                    if (state.start_latched)
                    begin
                        nx.mode          = MODE_RUN;
                        nx.start_latched = 1'b0;
                        nx.relay_delay   = cfg.relay_delay_ticks;
                    end
                    else if (item.charge_request)
                    begin
                        nx.mode        = MODE_CHARGE;
                        nx.relay_delay = cfg.relay_delay_ticks;
                    end
                end
                if (state.began_by_charge && !item.charge_request)
                    nx.mode = MODE_OFF;
                if (state.began_by_start && !item.vehicle_ready)
                    nx.mode = MODE_OFF;
                if (timed_out)
                begin
                    nx.pins.precharge_relay = 1'b0;
                    fault                   = 1'b1;
                    nx.mode                 = MODE_FAILED;
                end
            end
            MODE_FAILED:
            begin
                nx.start_latched        = 1'b0;
                nx.pins.precharge_relay = 1'b0;
                if (state.began_by_charge && !item.charge_request)
                    nx.mode = MODE_OFF;
                if (state.began_by_start && !item.vehicle_ready)
                    nx.mode = MODE_OFF;
            end
            MODE_CHARGE:
            begin
                nx.relay_delay = delay_dec;
                if (delay_dec == 8'd0)
                    nx.pins.main_contactor = 1'b1;
                clr_err = 1'b1;
                if (!item.charge_request)
                    nx.mode = MODE_OFF;
            end
            MODE_RUN:
            begin
                nx.relay_delay = delay_dec;
                if (delay_dec == 8'd0)
                    nx.pins.main_contactor = 1'b1;
                clr_err = 1'b1;
                if (!item.vehicle_ready)
                    nx.mode = MODE_OFF;
            end
            default:
            begin
                nx = state;
            end
        endcase
    end

    assign state_next             = nx;
    assign result.mode            = nx.mode;
    assign result.status_bits     = status;
    assign result.pins            = nx.pins;
    assign result.precharge_fault = fault;
    assign result.clear_errors    = clr_err;

endmodule

`default_nettype wire
